// ----- src/vector2_arith_unit_core_macros.svh -----
// ----------------------------------------------------------------------------
// vector2_arith_unit_core assertion macros
// concurrent checks on clk_i / rst_ni, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef VECTOR2_ARITH_UNIT_CORE_MACROS_SVH
`define VECTOR2_ARITH_UNIT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define V2AU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define V2AU_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define V2AU_ASSERT_IMP(name, ante, cons, msg)
`define V2AU_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

// ----- src/v2au_pkg.sv -----
// ----------------------------------------------------------------------------
// v2au_pkg
// shared types, widths and helpers of the 2d vector arithmetic unit
// ----------------------------------------------------------------------------
package v2au_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int ROOT_W   = WORD_BITS + 1;              // root of a 66 bit squared sum
  localparam int NUM_W    = WORD_BITS + FRAC_BITS + 1;  // divider numerator / quotient
  localparam int PACK_W   = 2 * WORD_BITS + 2;          // widest magnitude before packing
  localparam int DOT_W    = 2 * WORD_BITS + 1;          // signed lane product

  localparam int SQRT_LAT   = ROOT_W + 2;
  localparam int DIV_LAT    = NUM_W;
  localparam int LANE_AT    = SQRT_LAT + DIV_LAT;
  localparam int PIPE_DEPTH = LANE_AT + 4;

  localparam int ACT_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = ((5 * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 3 * WORD_BITS + 1;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [PACK_W-1:0]    ROUND_HALF = PACK_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD       = 4'd0,
    ACT_SUB       = 4'd1,
    ACT_SCALE     = 4'd2,
    ACT_DIVIDE    = 4'd3,
    ACT_NORMALIZE = 4'd4,
    ACT_MAGNITUDE = 4'd5,
    ACT_DISTANCE  = 4'd6,
    ACT_DOT       = 4'd7,
    ACT_EQUAL     = 4'd8
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  typedef struct packed {
    action_e                     action;
    logic signed [WORD_BITS-1:0] ax;
    logic signed [WORD_BITS-1:0] ay;
    logic signed [WORD_BITS-1:0] bx;
    logic signed [WORD_BITS-1:0] by;
    logic signed [WORD_BITS-1:0] f;
  } item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res;
    logic                        sat;
    logic signed [DOT_W-1:0]     dot;
  } lane_res_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_x;
    logic signed [WORD_BITS-1:0] res_y;
    logic signed [WORD_BITS-1:0] res_scalar;
    logic                        equal_flag;
    status_e                     status;
  } result_t;

  typedef struct packed {
    logic                 sat;
    logic [WORD_BITS-1:0] val;
  } pack_t;

  function automatic logic [WORD_BITS-1:0] abs_word(input logic [WORD_BITS-1:0] x);
    return x[WORD_BITS-1] ? (~x + 1'b1) : x;
  endfunction

  // magnitude and sign to a saturated word
  function automatic pack_t pack_mag(input logic [PACK_W-1:0] m, input logic neg);
    logic [PACK_W-1:0] lim;
    logic [PACK_W-1:0] v;
    logic [PACK_W-1:0] s;
    pack_t             r;
    lim   = neg ? (PACK_W'(1) << (WORD_BITS - 1)) : ((PACK_W'(1) << (WORD_BITS - 1)) - 1'b1);
    r.sat = (m > lim);
    v     = r.sat ? lim : m;
    s     = neg ? (~v + 1'b1) : v;
    r.val = s[WORD_BITS-1:0];
    return r;
  endfunction

endpackage

// ----- src/vector2_arith_unit_core.sv -----
// ----------------------------------------------------------------------------
// vector2_arith_unit_core
// 2d vector unit on q16.16 words: add, sub, scale, divide, normalize,
// magnitude, distance, dot and equality, saturating with a status code
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata ax,ay,bx,by,factor; tuser action
//  m_axis    out  m_axis_tvalid/tready        tdata res_x,res_y,res_scalar,equal_flag;
//                                              tuser status
//
//  one request per cycle while the output is not stalled; the latency is
//  dominated by the 33 stage square root followed by the 49 stage divider, one bit each
//  the whole pipeline advances together; it holds only while a result sits
//  unaccepted on m_axis, and s_axis_tready follows that same condition
//  rst_ni clears every valid bit; data registers are not reset
// ----------------------------------------------------------------------------
`include "vector2_arith_unit_core_macros.svh"

module vector2_arith_unit_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // ax, ay, bx, by, factor from bit 0 up
  input  logic [v2au_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // action
  input  logic [v2au_pkg::ACT_W-1:0]            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // res_x, res_y, res_scalar, equal_flag from bit 0 up, zero padded
  output logic [v2au_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // status
  output logic [v2au_pkg::STATUS_W-1:0]         m_axis_tuser
);

  localparam int W     = v2au_pkg::WORD_BITS;
  localparam int DEPTH = v2au_pkg::PIPE_DEPTH;
  localparam int SQL   = v2au_pkg::SQRT_LAT;
  localparam int DVL   = v2au_pkg::DIV_LAT;
  localparam int LA    = v2au_pkg::LANE_AT;

  // global advance: move whenever the output register is free or being drained
  logic pipe_en;

  logic                        out_vld_q;
  v2au_pkg::result_t           out_q;
  v2au_pkg::result_t           merge_res;

  logic [DEPTH-1:0]            vld_q;
  v2au_pkg::item_t             item_q [LA+3];
  v2au_pkg::item_t             in_item;

  // root carried alongside the divider and the lane stages
  logic [v2au_pkg::ROOT_W-1:0] root;
  logic [v2au_pkg::ROOT_W-1:0] root_q [DVL+2];

  logic [v2au_pkg::NUM_W-1:0]  num_x, num_y, quo_x, quo_y;
  logic [W-1:0]                den;
  v2au_pkg::lane_res_t         lane_x, lane_y;

  assign pipe_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // request unpacking
  always_comb begin
    in_item.action = v2au_pkg::action_e'(s_axis_tuser);
    in_item.ax     = $signed(s_axis_tdata[0*W +: W]);
    in_item.ay     = $signed(s_axis_tdata[1*W +: W]);
    in_item.bx     = $signed(s_axis_tdata[2*W +: W]);
    in_item.by     = $signed(s_axis_tdata[3*W +: W]);
    in_item.f      = $signed(s_axis_tdata[4*W +: W]);
  end

  // valid bits of every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      vld_q     <= {vld_q[DEPTH-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[DEPTH-1];
    end
  end

  // request and root delay lines
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      item_q[0] <= in_item;
      for (int k = 1; k < LA + 3; k++) begin
        item_q[k] <= item_q[k-1];
      end
      root_q[0] <= root;
      for (int k = 1; k < DVL + 2; k++) begin
        root_q[k] <= root_q[k-1];
      end
      out_q <= merge_res;
    end
  end

  // squared length and root, shared by normalize, magnitude and distance
  v2au_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .item_i (item_q[0]),
    .root_o (root)
  );

  // divisor is |factor| for divide and the length for normalize
  always_comb begin
    num_x = {v2au_pkg::abs_word(item_q[SQL].ax), {(v2au_pkg::FRAC_BITS+1){1'b0}}};
    num_y = {v2au_pkg::abs_word(item_q[SQL].ay), {(v2au_pkg::FRAC_BITS+1){1'b0}}};
    if (item_q[SQL].action == v2au_pkg::ACT_DIVIDE) begin
      den = v2au_pkg::abs_word(item_q[SQL].f);
    end else begin
      den = root[W-1:0];
    end
  end

  v2au_div u_div_x (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (num_x),
    .den_i (den),
    .quo_o (quo_x)
  );

  v2au_div u_div_y (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .num_i (num_y),
    .den_i (den),
    .quo_o (quo_y)
  );

  // x and y lanes
  v2au_lane u_lane_x (
    .clk_i       (clk_i),
    .en_i        (pipe_en),
    .action_i    (item_q[LA].action),
    .a_i         (item_q[LA].ax),
    .b_i         (item_q[LA].bx),
    .f_i         (item_q[LA].f),
    .quo_i       (quo_x),
    .root_zero_i (root_q[DVL-1] == '0),
    .lane_o      (lane_x)
  );

  v2au_lane u_lane_y (
    .clk_i       (clk_i),
    .en_i        (pipe_en),
    .action_i    (item_q[LA].action),
    .a_i         (item_q[LA].ay),
    .b_i         (item_q[LA].by),
    .f_i         (item_q[LA].f),
    .quo_i       (quo_y),
    .root_zero_i (root_q[DVL-1] == '0),
    .lane_o      (lane_y)
  );

  // merge: dot sum, scalar pack, equality and status
  v2au_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (pipe_en),
    .item_i   (item_q[LA+2]),
    .root_i   (root_q[DVL+1]),
    .lane_x_i (lane_x),
    .lane_y_i (lane_y),
    .res_o    (merge_res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = v2au_pkg::OUT_DATA_W'({out_q.equal_flag, out_q.res_scalar,
                                                 out_q.res_y, out_q.res_x});
  assign m_axis_tuser  = out_q.status;

  `V2AU_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted request lost at pipeline entry")
  `V2AU_ASSERT_NXT(a_stall_holds, !pipe_en, $stable(vld_q) && $stable(out_vld_q), "pipeline moved while stalled")
  `V2AU_ASSERT_IMP(a_equal_alone, m_axis_tvalid && out_q.equal_flag, out_q.res_x == '0 && out_q.res_y == '0 && out_q.res_scalar == '0 && out_q.status == v2au_pkg::ST_OK, "equal result carries other fields")
  `V2AU_ASSERT_IMP(a_divz_no_scalar, m_axis_tvalid && out_q.status == v2au_pkg::ST_DIVZ, out_q.res_scalar == '0 && !out_q.equal_flag, "divide by zero result carries a scalar")

endmodule

// ----- src/v2au_sqrt.sv -----
// ----------------------------------------------------------------------------
// v2au_sqrt
// squared length of a or b-a, then a pipelined integer square root, one bit per stage
// ----------------------------------------------------------------------------
module v2au_sqrt (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  v2au_pkg::item_t                      item_i,
  output logic [v2au_pkg::ROOT_W-1:0]          root_o
);

  localparam int W    = v2au_pkg::WORD_BITS;
  localparam int RW   = v2au_pkg::ROOT_W;
  localparam int RADW = 2 * RW;
  localparam int REMW = RW + 2;

  logic signed [RW-1:0] vx, vy;
  logic [RW-1:0]        mx, my;
  logic [RADW-1:0]      sqx_q, sqy_q, sum_q;

  logic [REMW-1:0] rem_q [RW-1];
  logic [RADW-1:0] rad_q [RW-1];
  logic [RW-1:0]   rt_q  [RW];

  always_comb begin
    if (item_i.action == v2au_pkg::ACT_DISTANCE) begin
      vx = $signed({item_i.bx[W-1], item_i.bx}) - $signed({item_i.ax[W-1], item_i.ax});
      vy = $signed({item_i.by[W-1], item_i.by}) - $signed({item_i.ay[W-1], item_i.ay});
    end else begin
      vx = $signed({item_i.ax[W-1], item_i.ax});
      vy = $signed({item_i.ay[W-1], item_i.ay});
    end
    mx = vx[RW-1] ? (~vx + 1'b1) : vx;
    my = vy[RW-1] ? (~vy + 1'b1) : vy;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= mx * mx;
      sqy_q <= my * my;
      sum_q <= sqx_q + sqy_q;
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [REMW-1:0] rem_in, t, trial;
    logic [RADW-1:0] rad_in;
    logic [RW-1:0]   rt_in;
    logic            ge;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign rad_in = sum_q;
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign rad_in = rad_q[j-1];
      assign rt_in  = rt_q[j-1];
    end

    assign t     = {rem_in[RW-1:0], rad_in[RADW-1 -: 2]};
    assign trial = {rt_in, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_q[j] <= {rt_in[RW-2:0], ge};
      end
    end

    if (j < RW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? (t - trial) : t;
          rad_q[j] <= rad_in << 2;
        end
      end
    end
  end

  assign root_o = rt_q[RW-1];

endmodule

// ----- src/v2au_div.sv -----
// ----------------------------------------------------------------------------
// v2au_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module v2au_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [v2au_pkg::NUM_W-1:0]        num_i,
  input  logic [v2au_pkg::WORD_BITS-1:0]    den_i,
  output logic [v2au_pkg::NUM_W-1:0]        quo_o
);

  localparam int W  = v2au_pkg::WORD_BITS;
  localparam int NW = v2au_pkg::NUM_W;

  logic [W-1:0]  r_q   [NW-1];
  logic [NW-1:0] num_q [NW-1];
  logic [W-1:0]  d_q   [NW-1];
  logic [NW-1:0] q_q   [NW];

  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic [W-1:0]  r_in, d_in;
    logic [NW-1:0] num_in, q_in;
    logic [W:0]    t, diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign r_in   = '0;
      assign num_in = num_i;
      assign d_in   = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign r_in   = r_q[j-1];
      assign num_in = num_q[j-1];
      assign d_in   = d_q[j-1];
      assign q_in   = q_q[j-1];
    end

    assign t    = {r_in, num_in[NW-1]};
    assign diff = t - {1'b0, d_in};
    assign ge   = (t >= {1'b0, d_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[j] <= {q_in[NW-2:0], ge};
      end
    end

    if (j < NW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[j]   <= ge ? diff[W-1:0] : t[W-1:0];
          num_q[j] <= num_in << 1;
          d_q[j]   <= d_in;
        end
      end
    end
  end

  assign quo_o = q_q[NW-1];

endmodule

// ----- src/v2au_lane.sv -----
// ----------------------------------------------------------------------------
// v2au_lane
// one vector component: sum, product, rounding and saturation in two stages
// ----------------------------------------------------------------------------
module v2au_lane (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  v2au_pkg::action_e                       action_i,
  input  logic signed [v2au_pkg::WORD_BITS-1:0]   a_i,
  input  logic signed [v2au_pkg::WORD_BITS-1:0]   b_i,
  input  logic signed [v2au_pkg::WORD_BITS-1:0]   f_i,
  input  logic [v2au_pkg::NUM_W-1:0]              quo_i,
  input  logic                                    root_zero_i,
  output v2au_pkg::lane_res_t                     lane_o
);

  localparam int W  = v2au_pkg::WORD_BITS;
  localparam int NW = v2au_pkg::NUM_W;
  localparam int PW = v2au_pkg::PACK_W;

  v2au_pkg::action_e act_q;
  logic signed [W:0]  sum_q;
  logic [2*W-1:0]     prod_q;
  logic               psgn_q, dsgn_q, fz_q, rz_q;
  logic signed [W-1:0] a_q;
  logic [NW-1:0]      quo_q;

  logic [W-1:0]       amag, mmag;
  logic               msgn;
  logic signed [W:0]  sum_d;

  always_comb begin
    amag = v2au_pkg::abs_word(a_i);
    if (action_i == v2au_pkg::ACT_SCALE) begin
      mmag = v2au_pkg::abs_word(f_i);
      msgn = f_i[W-1];
    end else begin
      mmag = v2au_pkg::abs_word(b_i);
      msgn = b_i[W-1];
    end
    if (action_i == v2au_pkg::ACT_SUB) begin
      sum_d = $signed({a_i[W-1], a_i}) - $signed({b_i[W-1], b_i});
    end else begin
      sum_d = $signed({a_i[W-1], a_i}) + $signed({b_i[W-1], b_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act_q  <= action_i;
      sum_q  <= sum_d;
      prod_q <= amag * mmag;
      psgn_q <= a_i[W-1] ^ msgn;
      dsgn_q <= a_i[W-1] ^ f_i[W-1];
      fz_q   <= (f_i == '0);
      rz_q   <= root_zero_i;
      a_q    <= a_i;
      quo_q  <= quo_i;
    end
  end

  // second stage: round and pack
  logic [NW:0]         qinc;
  logic [PW-1:0]       qr, sc;
  v2au_pkg::pack_t     pk_sc, pk_dv, pk_nm;
  logic                sum_ovf;
  logic [W-1:0]        sum_w;
  v2au_pkg::lane_res_t lane_d;

  always_comb begin
    qinc    = {1'b0, quo_q} + 1'b1;
    qr      = PW'(qinc[NW:1]);
    sc      = (PW'(prod_q) + v2au_pkg::ROUND_HALF) >> v2au_pkg::FRAC_BITS;
    pk_sc   = v2au_pkg::pack_mag(sc, psgn_q);
    pk_dv   = v2au_pkg::pack_mag(qr, dsgn_q);
    pk_nm   = v2au_pkg::pack_mag(qr, a_q[W-1]);
    sum_ovf = sum_q[W] != sum_q[W-1];
    sum_w   = sum_ovf ? (sum_q[W] ? v2au_pkg::WORD_MIN : v2au_pkg::WORD_MAX) : sum_q[W-1:0];

    lane_d.res = '0;
    lane_d.sat = 1'b0;
    lane_d.dot = psgn_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});

    case (act_q)
      v2au_pkg::ACT_ADD, v2au_pkg::ACT_SUB: begin
        lane_d.res = sum_w;
        lane_d.sat = sum_ovf;
      end
      v2au_pkg::ACT_SCALE: begin
        lane_d.res = pk_sc.val;
        lane_d.sat = pk_sc.sat;
      end
      v2au_pkg::ACT_DIVIDE: begin
        if (fz_q) begin
          // divide by zero: push toward the end of the component's sign
          if (a_q[W-1])       lane_d.res = v2au_pkg::WORD_MIN;
          else if (a_q != '0) lane_d.res = v2au_pkg::WORD_MAX;
        end else begin
          lane_d.res = pk_dv.val;
          lane_d.sat = pk_dv.sat;
        end
      end
      v2au_pkg::ACT_NORMALIZE: begin
        if (rz_q) begin
          lane_d.res = a_q;
        end else begin
          lane_d.res = pk_nm.val;
          lane_d.sat = pk_nm.sat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o <= lane_d;
    end
  end

endmodule

// ----- src/v2au_merge.sv -----
// ----------------------------------------------------------------------------
// v2au_merge
// combines both lanes with the root: dot sum, scalar, equality and status
// ----------------------------------------------------------------------------
module v2au_merge (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  v2au_pkg::item_t                    item_i,
  input  logic [v2au_pkg::ROOT_W-1:0]        root_i,
  input  v2au_pkg::lane_res_t                lane_x_i,
  input  v2au_pkg::lane_res_t                lane_y_i,
  output v2au_pkg::result_t                  res_o
);

  localparam int PW = v2au_pkg::PACK_W;
  localparam int DW = v2au_pkg::DOT_W;

  v2au_pkg::action_e act_q;
  logic              eq_q, sat_q, fz_q;
  logic signed [v2au_pkg::WORD_BITS-1:0] rx_q, ry_q;
  logic signed [PW-1:0] dsum_q;
  logic [v2au_pkg::ROOT_W-1:0] root_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act_q  <= item_i.action;
      eq_q   <= (item_i.ax == item_i.bx) && (item_i.ay == item_i.by);
      fz_q   <= (item_i.f == '0);
      rx_q   <= lane_x_i.res;
      ry_q   <= lane_y_i.res;
      sat_q  <= lane_x_i.sat | lane_y_i.sat;
      dsum_q <= $signed({lane_x_i.dot[DW-1], lane_x_i.dot})
              + $signed({lane_y_i.dot[DW-1], lane_y_i.dot});
      root_q <= root_i;
    end
  end

  logic [PW-1:0]   dmag, dr;
  v2au_pkg::pack_t pk_dot, pk_rt;
  logic            sat_s;

  always_comb begin
    dmag   = dsum_q[PW-1] ? (~dsum_q + 1'b1) : dsum_q;
    dr     = (dmag + v2au_pkg::ROUND_HALF) >> v2au_pkg::FRAC_BITS;
    pk_dot = v2au_pkg::pack_mag(dr, dsum_q[PW-1]);
    pk_rt  = v2au_pkg::pack_mag(PW'(root_q), 1'b0);

    res_o.res_x      = rx_q;
    res_o.res_y      = ry_q;
    res_o.res_scalar = '0;
    res_o.equal_flag = 1'b0;
    sat_s            = 1'b0;

    case (act_q)
      v2au_pkg::ACT_MAGNITUDE, v2au_pkg::ACT_DISTANCE: begin
        res_o.res_scalar = pk_rt.val;
        sat_s            = pk_rt.sat;
      end
      v2au_pkg::ACT_DOT: begin
        res_o.res_scalar = pk_dot.val;
        sat_s            = pk_dot.sat;
      end
      v2au_pkg::ACT_EQUAL: begin
        res_o.equal_flag = eq_q;
      end
      default: begin
      end
    endcase

    if (act_q == v2au_pkg::ACT_DIVIDE && fz_q) begin
      res_o.status = v2au_pkg::ST_DIVZ;
    end else if (sat_q || sat_s) begin
      res_o.status = v2au_pkg::ST_SAT;
    end else begin
      res_o.status = v2au_pkg::ST_OK;
    end
  end

endmodule
